FILE: src/opt_pkg.sv
// Shared types, constants and tables of the pilot phase tracker.
`default_nettype none
package opt_pkg;

	localparam int CORDIC_STEPS    = 14;
	localparam int CORDIC_INV_GAIN = 19898;
	localparam int DIVN_W          = 38;
	localparam int DIVD_W          = 20;
	localparam int BLOCK_COUNT_MAX = 127;

	localparam logic [1:0] CFG_PILOT_COUNT     = 2'd0;
	localparam logic [1:0] CFG_PILOT_POSITIONS = 2'd1;
	localparam logic [1:0] CFG_DATA_MASK       = 2'd2;
	localparam logic [1:0] CFG_DATA_TABLE_LEN  = 2'd3;

	typedef struct packed {
		logic fill_wr;
		logic dec;
		logic rd;
		logic sel_pilot;
		logic cordic_start;
		logic cordic_vec;
		logic ang_line;
		logic rot_wr;
		logic pil_upd;
		logic fit1;
		logic fit2;
		logic fit3;
		logic lin_ld;
		logic div_start;
		logic line_upd;
		logic out_ld;
		logic out_last;
	} cmd_t;

	typedef struct packed {
		logic       is_data;
		logic       had_data;
		logic       n_zero;
		logic       cordic_done;
		logic       div_done;
		logic       out_free;
		logic [3:0] n_eff;
	} status_t;

	// arctangent of 2^-i in binary-angle units
	function automatic logic [13:0] atan_lut(input logic [3:0] i);
		case (i)
			4'd0:    return 14'd8192;
			4'd1:    return 14'd4836;
			4'd2:    return 14'd2555;
			4'd3:    return 14'd1297;
			4'd4:    return 14'd651;
			4'd5:    return 14'd326;
			4'd6:    return 14'd163;
			4'd7:    return 14'd81;
			4'd8:    return 14'd41;
			4'd9:    return 14'd20;
			4'd10:   return 14'd10;
			4'd11:   return 14'd5;
			4'd12:   return 14'd3;
			4'd13:   return 14'd1;
			default: return 14'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: src/opt_cordic.sv
// Iterative CORDIC, shared between rotation and vectoring modes.
`default_nettype none
module opt_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               vec,
	input  wire logic signed [15:0] x_in,
	input  wire logic signed [15:0] y_in,
	input  wire logic        [15:0] z_in,
	output logic                    done,
	output logic signed [15:0]      x_out,
	output logic signed [15:0]      y_out,
	output logic        [15:0]      z_out
);

	logic               busy_q, scale_q, done_q, vec_q, zero_q;
	logic [3:0]         step_q;
	logic signed [19:0] x_q, y_q, dx, dy, x_ext, y_ext;
	logic signed [17:0] z_q, atn;
	logic signed [15:0] zs;
	logic signed [35:0] px, py, sx, sy;

	assign x_ext = 20'(x_in);
	assign y_ext = 20'(y_in);
	assign zs    = z_in;
	assign dx    = x_q >>> step_q;
	assign dy    = y_q >>> step_q;
	assign atn   = 18'(opt_pkg::atan_lut(step_q));
	assign px    = 36'(x_q) * 36'sd19898 + 36'sd16384;
	assign py    = 36'(y_q) * 36'sd19898 + 36'sd16384;
	assign sx    = px >>> 15;
	assign sy    = py >>> 15;

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		if (v > 36'sd32767)
			return 16'sh7fff;
		else if (v < -36'sd32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			scale_q <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 4'(opt_pkg::CORDIC_STEPS - 1)) begin
					busy_q  <= 1'b0;
					scale_q <= 1'b1;
				end
				step_q <= step_q + 4'd1;
			end else if (scale_q) begin
				scale_q <= 1'b0;
				done_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q  <= vec;
			zero_q <= (x_in == 16'sd0) && (y_in == 16'sd0);
			if (vec) begin
				if (x_in < 16'sd0) begin
					x_q <= -x_ext;
					y_q <= -y_ext;
					z_q <= 18'sd32768;
				end else begin
					x_q <= x_ext;
					y_q <= y_ext;
					z_q <= 18'sd0;
				end
			end else if (zs > 16'sd16384) begin
				x_q <= -x_ext;
				y_q <= -y_ext;
				z_q <= 18'(zs) - 18'sd32768;
			end else if (zs < -16'sd16384) begin
				x_q <= -x_ext;
				y_q <= -y_ext;
				z_q <= 18'(zs) + 18'sd32768;
			end else begin
				x_q <= x_ext;
				y_q <= y_ext;
				z_q <= 18'(zs);
			end
		end else if (busy_q) begin
			if (vec_q ? (y_q >= 20'sd0) : (z_q < 18'sd0)) begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
				z_q <= vec_q ? z_q + atn : z_q + atn;
			end else begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
				z_q <= z_q - atn;
			end
		end else if (scale_q) begin
			x_out <= sat16(sx);
			y_out <= sat16(sy);
		end
	end

	assign done  = done_q;
	assign z_out = zero_q ? 16'd0 : z_q[15:0];

endmodule
`default_nettype wire

FILE: src/opt_div.sv
// Bit-serial restoring divider with round-to-nearest, ties away from zero.
`default_nettype none
module opt_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [opt_pkg::DIVN_W-1:0]  numer,
	input  wire logic        [opt_pkg::DIVD_W-1:0]  denom,
	output logic                                    done,
	output logic [15:0]                             y
);

	localparam int NW = opt_pkg::DIVN_W;
	localparam int DW = opt_pkg::DIVD_W;

	logic          busy_q, done_q, neg_q;
	logic [5:0]    cnt_q;
	logic [DW:0]   rem_q, rem_sh;
	logic [NW-1:0] quo_q, mag;
	logic [DW-1:0] den_q;
	logic          ge;

	assign mag    = (numer < 0 ? NW'(-numer) : NW'(numer)) + NW'(denom >> 1);
	assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= numer < 0;
			den_q <= denom;
			quo_q <= mag;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign y    = neg_q ? 16'd0 - quo_q[15:0] : quo_q[15:0];

endmodule
`default_nettype wire

FILE: src/opt_dp.sv
// Datapath: symbol buffer, phase history, line fit, CORDIC and divider.
`default_nettype none
module opt_dp #(
	parameter int VLEN             = 64,
	parameter int MAX_PILOTS       = 8,
	parameter int DATA_TABLE_DEPTH = 64,
	localparam int IDX_W           = $clog2(VLEN),
	localparam int KW              = $clog2(MAX_PILOTS + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire opt_pkg::cmd_t      cmd,
	input  wire logic [IDX_W-1:0]   idx,
	input  wire logic [KW-1:0]      pilot_k,
	output opt_pkg::status_t        st,
	input  wire logic signed [15:0] sample_re,
	input  wire logic signed [15:0] sample_im,
	input  wire logic               frame_start,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [15:0]      out_re,
	output logic signed [15:0]      out_im,
	output logic                    last_of_symbol,
	input  wire logic               cfg_wr,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);

	localparam int HALF = VLEN / 2 - 1;

	logic [3:0]  pilot_count_q;
	logic [47:0] pilot_positions_q;
	logic [63:0] data_mask_q;
	logic [6:0]  data_table_len_q;

	logic [31:0] buf_mem [VLEN];
	logic [15:0] acc_mem [VLEN];
	logic [VLEN-1:0] acc_valid_q, pilot_flag_q;
	logic [31:0] buf_rd_q;
	logic [15:0] acc_rd_q;
	logic [IDX_W-1:0] rd_addr_q, rd_addr, pilot_pos;
	logic [6:0]  block_count_q, len_eff;
	logic        had_data_q;
	logic [3:0]  n_eff;
	logic signed [4:0] n_s;

	logic signed [19:0] sb_q;
	logic signed [9:0]  st_q;
	logic signed [16:0] stt_q;
	logic signed [24:0] stb_q;
	logic signed [19:0] nstt_q, st2_q;
	logic signed [29:0] nstb_q, stsb_q, num_q;
	logic signed [18:0] d_q;
	logic signed [32:0] numn_q;
	logic signed [37:0] sbd_q, dividend_q;
	logic [19:0] nd_q;

	logic signed [7:0]  t_val, u_val;
	logic signed [15:0] beta;
	logic [15:0] acc_cur, line_y, div_y, z_sel, cx_z;
	logic signed [15:0] cx_re, cx_im;
	logic cordic_done, div_done;
	logic [6:0] pm;

	// pilot position taken modulo VLEN
	always_comb begin
		pm = 7'(pilot_positions_q[6 * int'(pilot_k) +: 6]);
		for (int s = 4; s >= 0; s--) begin
			if (int'(pm) >= (VLEN << s))
				pm = pm - 7'(VLEN << s);
		end
		pilot_pos = pm[IDX_W-1:0];
	end

	assign n_eff   = (pilot_count_q > 4'(MAX_PILOTS)) ? 4'(MAX_PILOTS) : pilot_count_q;
	assign n_s     = {1'b0, n_eff};
	assign len_eff = (data_table_len_q > 7'(DATA_TABLE_DEPTH)) ?
		7'(DATA_TABLE_DEPTH) : data_table_len_q;
	assign rd_addr = cmd.sel_pilot ? pilot_pos : idx;
	assign t_val   = 8'(rd_addr_q) - 8'(HALF);
	assign u_val   = 8'(idx) - 8'(HALF);
	assign acc_cur = acc_valid_q[rd_addr_q] ? acc_rd_q : 16'd0;
	assign beta    = cx_z;
	assign line_y  = (n_eff == 4'd0) ? 16'd0 : div_y;
	assign z_sel   = cmd.ang_line ? 16'd0 - line_y : 16'd0 - acc_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pilot_count_q     <= 4'd4;
			pilot_positions_q <= '0;
			data_mask_q       <= '0;
			data_table_len_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				opt_pkg::CFG_PILOT_COUNT:     pilot_count_q     <= cfg_data[3:0];
				opt_pkg::CFG_PILOT_POSITIONS: pilot_positions_q <= cfg_data[47:0];
				opt_pkg::CFG_DATA_MASK:       data_mask_q       <= cfg_data;
				opt_pkg::CFG_DATA_TABLE_LEN:  data_table_len_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// symbol buffer and phase history
	always_ff @(posedge clk) begin
		if (cmd.fill_wr)
			buf_mem[idx] <= {sample_re, sample_im};
		else if (cmd.rot_wr)
			buf_mem[rd_addr_q] <= {cx_re, cx_im};
		if (cmd.rd) begin
			buf_rd_q  <= buf_mem[rd_addr];
			acc_rd_q  <= acc_mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (cmd.pil_upd)
			acc_mem[rd_addr_q] <= acc_cur + beta;
		else if (cmd.line_upd && !pilot_flag_q[rd_addr_q])
			acc_mem[rd_addr_q] <= acc_cur + line_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_q   <= '0;
			pilot_flag_q  <= '0;
			had_data_q    <= 1'b0;
			block_count_q <= '0;
		end else begin
			if (cmd.fill_wr && idx == '0 && frame_start) begin
				acc_valid_q   <= '0;
				had_data_q    <= 1'b0;
				block_count_q <= '0;
			end
			if (cmd.dec) begin
				pilot_flag_q <= '0;
				if (st.is_data)
					had_data_q <= 1'b1;
				if (block_count_q != 7'(opt_pkg::BLOCK_COUNT_MAX))
					block_count_q <= block_count_q + 7'd1;
			end
			if (cmd.pil_upd) begin
				acc_valid_q[rd_addr_q]  <= 1'b1;
				pilot_flag_q[rd_addr_q] <= 1'b1;
			end else if (cmd.line_upd && !pilot_flag_q[rd_addr_q]) begin
				acc_valid_q[rd_addr_q] <= 1'b1;
			end
		end
	end

	// pilot sums and line coefficients
	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			sb_q  <= '0;
			st_q  <= '0;
			stt_q <= '0;
			stb_q <= '0;
		end else if (cmd.pil_upd) begin
			sb_q  <= sb_q + 20'(beta);
			st_q  <= st_q + 10'(t_val);
			stt_q <= stt_q + 17'(t_val) * 17'(t_val);
			stb_q <= stb_q + 25'(t_val) * 25'(beta);
		end
		if (cmd.fit1) begin
			nstt_q <= 20'(n_s) * 20'(stt_q);
			st2_q  <= 20'(st_q) * 20'(st_q);
			nstb_q <= 30'(n_s) * 30'(stb_q);
			stsb_q <= 30'(st_q) * 30'(sb_q);
		end
		if (cmd.fit2) begin
			d_q   <= 19'(nstt_q - st2_q);
			num_q <= nstb_q - stsb_q;
		end
		if (cmd.fit3) begin
			if (d_q == 19'sd0) begin
				// degenerate fit: rounded mean only
				numn_q <= '0;
				sbd_q  <= 38'(sb_q);
				nd_q   <= 20'(n_eff);
			end else begin
				numn_q <= 33'(num_q) * 33'(n_s);
				sbd_q  <= 38'(sb_q) * 38'(d_q);
				nd_q   <= 20'(n_eff) * 20'(d_q[16:0]);
			end
		end
		if (cmd.lin_ld)
			dividend_q <= 38'(numn_q) * 38'(u_val) + sbd_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (cmd.out_ld)
			result_valid <= 1'b1;
		else if (!result_stall)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_re         <= buf_rd_q[31:16];
			out_im         <= buf_rd_q[15:0];
			last_of_symbol <= cmd.out_last;
		end
	end

	opt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cordic_start),
		.vec    (cmd.cordic_vec),
		.x_in   (buf_rd_q[31:16]),
		.y_in   (buf_rd_q[15:0]),
		.z_in   (z_sel),
		.done   (cordic_done),
		.x_out  (cx_re),
		.y_out  (cx_im),
		.z_out  (cx_z)
	);

	opt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (dividend_q),
		.denom  (nd_q),
		.done   (div_done),
		.y      (div_y)
	);

	assign st.is_data     = !((block_count_q < len_eff) && !data_mask_q[block_count_q[5:0]]);
	assign st.had_data    = had_data_q;
	assign st.n_zero      = n_eff == 4'd0;
	assign st.cordic_done = cordic_done;
	assign st.div_done    = div_done;
	assign st.out_free    = !result_valid || !result_stall;
	assign st.n_eff       = n_eff;

endmodule
`default_nettype wire

FILE: src/opt_ctrl.sv
// Sequencer: symbol fill, derotation, pilot fit, line rotation and readout.
`default_nettype none
module opt_ctrl #(
	parameter int VLEN       = 64,
	parameter int MAX_PILOTS = 8,
	localparam int IDX_W     = $clog2(VLEN),
	localparam int KW        = $clog2(MAX_PILOTS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire opt_pkg::status_t  st,
	output opt_pkg::cmd_t          cmd,
	output logic [IDX_W-1:0]       idx,
	output logic [KW-1:0]          pilot_k
);

	typedef enum logic [17:0] {
		S_FILL     = 18'h00001,
		S_DECIDE   = 18'h00002,
		S_ROT_RD   = 18'h00004,
		S_ROT_GO   = 18'h00008,
		S_ROT_WAIT = 18'h00010,
		S_PIL_RD   = 18'h00020,
		S_PIL_GO   = 18'h00040,
		S_PIL_WAIT = 18'h00080,
		S_FIT1     = 18'h00100,
		S_FIT2     = 18'h00200,
		S_FIT3     = 18'h00400,
		S_LIN_RD   = 18'h00800,
		S_LIN_DIV  = 18'h01000,
		S_LIN_WAIT = 18'h02000,
		S_LIN_GO   = 18'h04000,
		S_LIN_ROT  = 18'h08000,
		S_OUT_RD   = 18'h10000,
		S_OUT_LD   = 18'h20000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic [KW-1:0]    k_q, k_d, k_nxt;
	logic             cnt_last;

	assign cnt_last = cnt_q == IDX_W'(VLEN - 1);
	assign k_nxt    = k_q + KW'(1);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		unique case (state_q)
			S_FILL: begin
				cmd.fill_wr = sample_valid;
				if (sample_valid) begin
					cnt_d = cnt_last ? '0 : cnt_q + IDX_W'(1);
					if (cnt_last)
						state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.dec = 1'b1;
				cnt_d   = '0;
				k_d     = '0;
				if (!st.is_data)
					state_d = S_OUT_RD;
				else if (st.had_data)
					state_d = S_ROT_RD;
				else
					state_d = st.n_zero ? S_FIT1 : S_PIL_RD;
			end
			S_ROT_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_ROT_GO;
			end
			S_ROT_GO: begin
				cmd.cordic_start = 1'b1;
				state_d          = S_ROT_WAIT;
			end
			S_ROT_WAIT: begin
				if (st.cordic_done) begin
					cmd.rot_wr = 1'b1;
					if (cnt_last) begin
						cnt_d   = '0;
						state_d = st.n_zero ? S_FIT1 : S_PIL_RD;
					end else begin
						cnt_d   = cnt_q + IDX_W'(1);
						state_d = S_ROT_RD;
					end
				end
			end
			S_PIL_RD: begin
				cmd.rd        = 1'b1;
				cmd.sel_pilot = 1'b1;
				state_d       = S_PIL_GO;
			end
			S_PIL_GO: begin
				cmd.cordic_start = 1'b1;
				cmd.cordic_vec   = 1'b1;
				state_d          = S_PIL_WAIT;
			end
			S_PIL_WAIT: begin
				if (st.cordic_done) begin
					cmd.pil_upd = 1'b1;
					k_d         = k_nxt;
					state_d     = (k_nxt == KW'(st.n_eff)) ? S_FIT1 : S_PIL_RD;
				end
			end
			S_FIT1: begin
				cmd.fit1 = 1'b1;
				state_d  = S_FIT2;
			end
			S_FIT2: begin
				cmd.fit2 = 1'b1;
				state_d  = S_FIT3;
			end
			S_FIT3: begin
				cmd.fit3 = 1'b1;
				cnt_d    = '0;
				state_d  = S_LIN_RD;
			end
			S_LIN_RD: begin
				cmd.rd     = 1'b1;
				cmd.lin_ld = 1'b1;
				state_d    = S_LIN_DIV;
			end
			S_LIN_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = S_LIN_WAIT;
			end
			S_LIN_WAIT: begin
				if (st.div_done)
					state_d = S_LIN_GO;
			end
			S_LIN_GO: begin
				cmd.cordic_start = 1'b1;
				cmd.ang_line     = 1'b1;
				state_d          = S_LIN_ROT;
			end
			S_LIN_ROT: begin
				cmd.ang_line = 1'b1;
				if (st.cordic_done) begin
					cmd.rot_wr   = 1'b1;
					cmd.line_upd = 1'b1;
					if (cnt_last) begin
						cnt_d   = '0;
						state_d = S_OUT_RD;
					end else begin
						cnt_d   = cnt_q + IDX_W'(1);
						state_d = S_LIN_RD;
					end
				end
			end
			S_OUT_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_OUT_LD;
			end
			S_OUT_LD: begin
				if (st.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_last = cnt_last;
					if (cnt_last) begin
						cnt_d   = '0;
						state_d = S_FILL;
					end else begin
						cnt_d   = cnt_q + IDX_W'(1);
						state_d = S_OUT_RD;
					end
				end
			end
			default: state_d = S_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
		end
	end

	assign sample_stall = state_q != S_FILL;
	assign idx          = cnt_q;
	assign pilot_k      = k_q;

	a_rot_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rot_wr |-> st.cordic_done)
		else $error("buffer written back without a finished rotation");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> st.out_free)
		else $error("result register overwritten before transfer");

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !st.div_done)
		else $error("divider finished in one cycle");

	a_pilot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pil_upd |-> (int'(k_q) < int'(st.n_eff)))
		else $error("pilot index beyond pilot count");

endmodule
`default_nettype wire

FILE: src/ofdm_pilot_phase_tracker_unit.sv
// Top level of the OFDM pilot-based linear phase tracker.
//
// channel   direction  handshake                   payload
// sample    in         sample_valid / sample_stall sample_re, sample_im, frame_start
// result    out        result_valid / result_stall out_re, out_im, last_of_symbol
// cfg       in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// Fill takes one cycle per subcarrier; samples stall while a symbol is processed.
// Processing a data symbol runs the 14-step iterative CORDIC (derotation, pilot
// angles, line rotation) and the 38-step serial divider of the line fit; a
// non-data symbol is only read out. Results leave through one output register.
// Reset clears the phase history at once through per-carrier valid flags.
`default_nettype none
module ofdm_pilot_phase_tracker_unit #(
	parameter int VLEN             = 64,
	parameter int MAX_PILOTS       = 8,
	parameter int DATA_TABLE_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	input  wire logic signed [15:0] sample_re,
	input  wire logic signed [15:0] sample_im,
	input  wire logic               frame_start,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [15:0]      out_re,
	output logic signed [15:0]      out_im,
	output logic                    last_of_symbol,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);

	localparam int IDX_W = $clog2(VLEN);
	localparam int KW    = $clog2(MAX_PILOTS + 1);

	opt_pkg::cmd_t    cmd;
	opt_pkg::status_t st;
	logic [IDX_W-1:0] idx;
	logic [KW-1:0]    pilot_k;

	assign cfg_ready = 1'b1;

	opt_ctrl #(
		.VLEN       (VLEN),
		.MAX_PILOTS (MAX_PILOTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.st           (st),
		.cmd          (cmd),
		.idx          (idx),
		.pilot_k      (pilot_k)
	);

	opt_dp #(
		.VLEN             (VLEN),
		.MAX_PILOTS       (MAX_PILOTS),
		.DATA_TABLE_DEPTH (DATA_TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.idx            (idx),
		.pilot_k        (pilot_k),
		.st             (st),
		.sample_re      (sample_re),
		.sample_im      (sample_im),
		.frame_start    (frame_start),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_re         (out_re),
		.out_im         (out_im),
		.last_of_symbol (last_of_symbol),
		.cfg_wr         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

endmodule
`default_nettype wire

FILE: dv/ofdm_pilot_phase_tracker_unit_chk.sv
// Checker for the pilot phase tracker: watches the channels, predicts results, compares.
`timescale 1ns / 1ps
module ofdm_pilot_phase_tracker_unit_chk (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	input  wire logic               sample_stall,
	input  wire logic signed [15:0] sample_re,
	input  wire logic signed [15:0] sample_im,
	input  wire logic               frame_start,
	input  wire logic               result_valid,
	input  wire logic               result_stall,
	input  wire logic signed [15:0] out_re,
	input  wire logic signed [15:0] out_im,
	input  wire logic               last_of_symbol,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	output int                      fails,
	output int                      pending
);

	localparam int NCAR = 64;
	localparam int HALF = NCAR / 2 - 1;
	localparam int ATAN_BAM [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
		10, 5, 3, 1};

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               last;
	} carrier_t;

	carrier_t carrier_q[$];

	logic [3:0]  pilot_cnt;
	logic [47:0] pilot_pos;
	logic [63:0] data_mask;
	logic [6:0]  table_len;

	int          fill_re [NCAR];
	int          fill_im [NCAR];
	logic [15:0] phase_hist [NCAR];
	logic [6:0]  sym_cnt;
	logic        seen_data;
	int          fill_idx;

	function automatic int sat16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic void derotate(inout int re, inout int im, input logic [15:0] a);
		int x, y, z, dx, dy;
		x = re;
		y = im;
		z = int'($signed(a));
		if (z > 16384) begin
			z -= 32768; x = -x; y = -y;
		end else if (z < -16384) begin
			z += 32768; x = -x; y = -y;
		end
		for (int i = 0; i < 14; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (z >= 0) begin
				x -= dy; y += dx; z -= ATAN_BAM[i];
			end else begin
				x += dy; y -= dx; z += ATAN_BAM[i];
			end
		end
		re = sat16((x * 19898 + 16384) >>> 15);
		im = sat16((y * 19898 + 16384) >>> 15);
	endfunction

	function automatic logic [15:0] pilot_angle(input int re, input int im);
		int x, y, z, dx, dy;
		x = re;
		y = im;
		z = 0;
		if (x == 0 && y == 0) return 16'd0;
		if (x < 0) begin
			x = -x; y = -y; z = 32768;
		end
		for (int i = 0; i < 14; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy; y -= dx; z += ATAN_BAM[i];
			end else begin
				x -= dy; y += dx; z -= ATAN_BAM[i];
			end
		end
		return z[15:0];
	endfunction

	function automatic longint round_div(input longint n, input longint d);
		longint m, q;
		m = n < 0 ? -n : n;
		q = (m + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	// runs the fit and compensation of one full symbol if it is data, queues its carriers
	function automatic void track_symbol();
		int re [NCAR];
		int im [NCAR];
		bit pilot_at [NCAR];
		int n, len, p;
		longint sb, st, stt, stb, d, num, b, t, line;
		logic [15:0] ang, y;
		carrier_t c;
		for (int i = 0; i < NCAR; i++) begin
			re[i] = fill_re[i];
			im[i] = fill_im[i];
			pilot_at[i] = 0;
		end
		n = pilot_cnt > 8 ? 8 : int'(pilot_cnt);
		len = table_len > 64 ? 64 : int'(table_len);
		if (!(int'(sym_cnt) < len && !data_mask[sym_cnt])) begin
			if (seen_data)
				for (int i = 0; i < NCAR; i++)
					derotate(re[i], im[i], 16'(16'd0 - phase_hist[i]));
			sb = 0; st = 0; stt = 0; stb = 0;
			for (int k = 0; k < n; k++) begin
				p = int'(pilot_pos[6*k +: 6]) % NCAR;
				pilot_at[p] = 1;
				ang = pilot_angle(re[p], im[p]);
				b = longint'($signed(ang));
				t = p - HALF;
				sb += b; st += t; stt += t * t; stb += t * b;
				phase_hist[p] = phase_hist[p] + ang;
			end
			d = n * stt - st * st;
			num = n * stb - st * sb;
			for (int i = 0; i < NCAR; i++) begin
				if (n == 0) line = 0;
				else if (d == 0) line = round_div(sb, n);
				else line = round_div(num * (i - HALF) * n + sb * d, n * d);
				y = line[15:0];
				derotate(re[i], im[i], 16'(16'd0 - y));
				if (!pilot_at[i]) phase_hist[i] = phase_hist[i] + y;
			end
			seen_data = 1;
		end
		if (sym_cnt < 7'd127) sym_cnt++;
		for (int i = 0; i < NCAR; i++) begin
			c.re = re[i][15:0];
			c.im = im[i][15:0];
			c.last = (i == NCAR - 1);
			carrier_q.push_back(c);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		carrier_t e;
		int nerr;
		if (!arst_n) begin
			pilot_cnt <= 4'd4;
			pilot_pos <= '0;
			data_mask <= '0;
			table_len <= '0;
			sym_cnt = '0;
			seen_data = 0;
			fill_idx = 0;
			for (int i = 0; i < NCAR; i++) phase_hist[i] = '0;
			carrier_q.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			nerr = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					opt_pkg::CFG_PILOT_COUNT:     pilot_cnt <= cfg_data[3:0];
					opt_pkg::CFG_PILOT_POSITIONS: pilot_pos <= cfg_data[47:0];
					opt_pkg::CFG_DATA_MASK:       data_mask <= cfg_data;
					opt_pkg::CFG_DATA_TABLE_LEN:  table_len <= cfg_data[6:0];
				endcase
			end
			if (sample_valid && !sample_stall) begin
				if (fill_idx == 0 && frame_start) begin
					for (int i = 0; i < NCAR; i++) phase_hist[i] = '0;
					seen_data = 0;
					sym_cnt = '0;
				end
				fill_re[fill_idx] = int'(sample_re);
				fill_im[fill_idx] = int'(sample_im);
				if (fill_idx == NCAR - 1) begin
					fill_idx = 0;
					track_symbol();
				end else begin
					fill_idx++;
				end
			end
			if (result_valid && !result_stall) begin
				if (carrier_q.size() == 0) begin
					$error("result transfer with nothing expected");
					nerr++;
				end else begin
					e = carrier_q.pop_front();
					if (out_re !== e.re) begin
						$error("out_re expected %0d got %0d", e.re, out_re);
						nerr++;
					end
					if (out_im !== e.im) begin
						$error("out_im expected %0d got %0d", e.im, out_im);
						nerr++;
					end
					if (last_of_symbol !== e.last) begin
						$error("last_of_symbol expected %0b got %0b", e.last, last_of_symbol);
						nerr++;
					end
				end
			end
			fails <= fails + nerr;
			pending <= carrier_q.size();
		end
	end

endmodule

FILE: dv/ofdm_pilot_phase_tracker_unit_tb.sv
// Testbench top for the pilot phase tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module ofdm_pilot_phase_tracker_unit_tb;

	localparam int NCAR = 64;
	localparam int LIMIT = 1000000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               sample_valid = 0;
	logic               sample_stall;
	logic signed [15:0] sample_re = 0;
	logic signed [15:0] sample_im = 0;
	logic               frame_start = 0;
	logic               result_valid;
	logic               result_stall = 0;
	logic signed [15:0] out_re;
	logic signed [15:0] out_im;
	logic               last_of_symbol;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = 0;
	logic [63:0]        cfg_data = 0;

	int fails;
	int pending;
	int send_idle_pct = 21;
	int recv_idle_pct = 75;
	bit hold_go = 0;
	bit hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;

	ofdm_pilot_phase_tracker_unit dut (.*);

	ofdm_pilot_phase_tracker_unit_chk chk (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off to back up the block
	always @(posedge clk) begin
		if (hold_go && !hold_seen) begin
			hold_seen <= 1;
			hold_left <= 8000;
			result_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// drop valid, let the pending count catch up, then wait for every result
	task automatic wait_drained();
		sample_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_carrier(input logic [15:0] re, input logic [15:0] im, input logic fs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 0;
			@(posedge clk);
		end
		sample_valid <= 1;
		sample_re <= re;
		sample_im <= im;
		frame_start <= fs;
		do @(posedge clk); while (sample_stall);
	endtask

	// one symbol; the first carriers of the first symbol are the corner values
	task automatic send_symbol(input logic start, input bit corners);
		logic [15:0] corner_re [20] = '{16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000,
			16'h0000, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0000, 16'h5a82,
			16'ha57e, 16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h4000, 16'hc000};
		logic [15:0] corner_im [20] = '{16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff,
			16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h5a82,
			16'ha57e, 16'h0000, 16'h8000, 16'hffff, 16'h0001, 16'hffff, 16'hc000, 16'h4000};
		for (int i = 0; i < NCAR; i++) begin
			if (corners && i < 20)
				send_carrier(corner_re[i], corner_im[i], i == 0 ? start : 1'b1);
			else
				send_carrier(16'($urandom), 16'($urandom),
					i == 0 ? start : 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset setup: four pilots all on carrier 0, degenerate fit
		send_symbol(1'b1, 1);
		wait_drained();
		write_reg(opt_pkg::CFG_PILOT_COUNT, 64'd2);
		write_reg(opt_pkg::CFG_PILOT_POSITIONS, {16'd0, 32'd0, 4'd0, 6'd63, 6'd0});
		send_symbol(1'b0, 0);

		send_idle_pct = 75;
		recv_idle_pct = 21;
		wait_drained();
		write_reg(opt_pkg::CFG_PILOT_COUNT, 64'd15);
		write_reg(opt_pkg::CFG_PILOT_POSITIONS, {$urandom, $urandom});
		write_reg(opt_pkg::CFG_DATA_MASK, {$urandom, $urandom} & ~64'd1);
		write_reg(opt_pkg::CFG_DATA_TABLE_LEN, 64'd100);
		send_symbol(1'b1, 0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait_drained();
		write_reg(opt_pkg::CFG_PILOT_COUNT, 64'd8);
		write_reg(opt_pkg::CFG_PILOT_POSITIONS, {$urandom, $urandom});
		write_reg(opt_pkg::CFG_DATA_MASK, '1);
		write_reg(opt_pkg::CFG_DATA_TABLE_LEN, 64'd64);
		send_symbol(1'b0, 0);
		wait_drained();
		// no pilots, every symbol is data
		write_reg(opt_pkg::CFG_PILOT_COUNT, 64'd0);
		write_reg(opt_pkg::CFG_PILOT_POSITIONS, 64'hffff_ffff_ffff);
		write_reg(opt_pkg::CFG_DATA_MASK, 64'd0);
		write_reg(opt_pkg::CFG_DATA_TABLE_LEN, 64'd0);
		hold_go <= 1;
		send_symbol(1'($urandom_range(0, 1)), 0);
		send_symbol(1'($urandom_range(0, 1)), 0);

		wait_drained();
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
src/opt_pkg.sv
src/opt_cordic.sv
src/opt_div.sv
src/opt_dp.sv
src/opt_ctrl.sv
src/ofdm_pilot_phase_tracker_unit.sv
dv/ofdm_pilot_phase_tracker_unit_chk.sv
dv/ofdm_pilot_phase_tracker_unit_tb.sv
